FILE: sv/rtbb_pkg.sv
// Shared constants and codes of the region to bounding box converter.
package rtbb_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 4;

    // Fixed request and result field widths.
    localparam int POS_W  = 22;
    localparam int SIZE_W = 20;
    localparam int ST_W   = 2;
    localparam int KIND_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // Fraction bits of the Q.16 scale.
    localparam int SCALE_FRAC = 16;

    // Result bus packing.
    localparam int OUT_DW  = ((2 * POS_W + 2 * SIZE_W + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_DW - 2 * POS_W - 2 * SIZE_W;

    // Region formats.
    localparam logic [KIND_W-1:0] KIND_RECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUAD = 2'd1;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_KIND  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO_AREA = 2'd2;

endpackage

FILE: sv/region_to_bounding_box.sv
// Region to bounding box converter: fully pipelined top level.
// Throughput: one request per cycle while the output moves; edge roots, the 2^32
// divide and the scale root each run one result bit per pipeline stage.
// A stalled output freezes the whole pipe; the input is ready whenever the output moves.
// Reset (rst_n low, async) empties the pipe and sets center_mode to 1.
module region_to_bounding_box #(
    parameter int COORD_WIDTH = rtbb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rtbb_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // center_mode register write
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    // request side
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [8*COORD_WIDTH-1:0]    s_axis_tdata,  // coord_0 .. coord_7
    input  logic [rtbb_pkg::KIND_W-1:0] s_axis_tuser,  // kind
    // result side
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rtbb_pkg::OUT_DW-1:0] m_axis_tdata,  // box_x, box_y, box_width, box_height
    output logic [rtbb_pkg::ST_W-1:0]   m_axis_tuser   // status
);

    localparam int CW    = COORD_WIDTH;
    localparam int POS_W = rtbb_pkg::POS_W;
    localparam int SIZE_W = rtbb_pkg::SIZE_W;
    localparam int QF    = rtbb_pkg::SCALE_FRAC;
    localparam int LW    = CW + 1;          // edge length bits
    localparam int ERW   = LW + 2;          // edge root partial remainder
    localparam int A1W   = 2 * LW;          // product of edge lengths
    localparam int A2W   = 2 * CW;          // box area
    localparam int QW    = A1W + 2 * QF;    // quotient bits
    localparam int SW    = (QW + 1) / 2;    // scale root bits
    localparam int SRW   = SW + 2;
    localparam int PW    = SW + CW;         // scale times extent
    localparam int TW    = PW - QF + 1;     // size before saturation
    localparam int XW    = CW + POS_W;      // position math width

    localparam logic [TW-1:0] ONE_T  = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] SMAX_T = TW'(rtbb_pkg::SIZE_MAX);
    localparam logic signed [XW-1:0] SMAX_X = XW'(rtbb_pkg::SIZE_MAX);

    // Per-request info that rides along the whole pipe.
    typedef struct packed {
        logic [rtbb_pkg::ST_W-1:0] status;
        logic                      quad;
        logic                      center;
        logic [POS_W-1:0]          px;
        logic [POS_W-1:0]          py;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic signed [CW-1:0]      cx;
        logic signed [CW-1:0]      cy;
        logic [CW-1:0]             ex;
        logic [CW-1:0]             ey;
    } side_t;

    logic en;
    logic center_reg;

    // ---------------- stage 1: differences, min/max, sums, rectangle ----------------
    logic signed [CW-1:0] c [0:7];
    logic signed [CW:0]   dif [0:3];
    logic signed [CW-1:0] xa, xb, ya, yb, xc, xd, yc, yd;
    logic signed [XW-1:0] rx_c, ry_c, rw_x, rh_x;
    side_t                s1_side_next;
    logic [CW-1:0]        s1_mag_next [0:3];
    logic signed [CW-1:0] s1_xmin_next, s1_xmax_next, s1_ymin_next, s1_ymax_next;
    logic signed [CW+1:0] s1_sx_next, s1_sy_next;

    logic                 s1_vld_reg;
    side_t                s1_side_reg;
    logic [CW-1:0]        s1_mag_reg [0:3];
    logic signed [CW-1:0] s1_xmin_reg, s1_xmax_reg, s1_ymin_reg, s1_ymax_reg;
    logic signed [CW+1:0] s1_sx_reg, s1_sy_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            c[i] = s_axis_tdata[i*CW +: CW];
        end
        dif[0] = (CW+1)'(c[0]) - (CW+1)'(c[2]);
        dif[1] = (CW+1)'(c[1]) - (CW+1)'(c[3]);
        dif[2] = (CW+1)'(c[2]) - (CW+1)'(c[4]);
        dif[3] = (CW+1)'(c[3]) - (CW+1)'(c[5]);
        for (int i = 0; i < 4; i++)
        begin
            s1_mag_next[i] = dif[i][CW] ? CW'(-dif[i]) : dif[i][CW-1:0];
        end
        xa = (c[0] < c[2]) ? c[0] : c[2];
        xb = (c[4] < c[6]) ? c[4] : c[6];
        xc = (c[0] > c[2]) ? c[0] : c[2];
        xd = (c[4] > c[6]) ? c[4] : c[6];
        ya = (c[1] < c[3]) ? c[1] : c[3];
        yb = (c[5] < c[7]) ? c[5] : c[7];
        yc = (c[1] > c[3]) ? c[1] : c[3];
        yd = (c[5] > c[7]) ? c[5] : c[7];
        s1_xmin_next = (xa < xb) ? xa : xb;
        s1_xmax_next = (xc > xd) ? xc : xd;
        s1_ymin_next = (ya < yb) ? ya : yb;
        s1_ymax_next = (yc > yd) ? yc : yd;
        s1_sx_next = (CW+2)'(c[0]) + (CW+2)'(c[2]) + (CW+2)'(c[4]) + (CW+2)'(c[6]);
        s1_sy_next = (CW+2)'(c[1]) + (CW+2)'(c[3]) + (CW+2)'(c[5]) + (CW+2)'(c[7]);

        // rectangle: position and clamped size
        rx_c = XW'(c[0]) + XW'(c[2] >>> 1);
        ry_c = XW'(c[1]) + XW'(c[3] >>> 1);
        rw_x = XW'(c[2]);
        rh_x = XW'(c[3]);

        s1_side_next = '0;
        s1_side_next.center = center_reg;
        case (s_axis_tuser)
            rtbb_pkg::KIND_RECT:
            begin
                s1_side_next.status = rtbb_pkg::ST_OK;
                s1_side_next.px = center_reg ? rx_c[POS_W-1:0] : POS_W'(c[0]);
                s1_side_next.py = center_reg ? ry_c[POS_W-1:0] : POS_W'(c[1]);
                s1_side_next.w  = c[2][CW-1] ? '0 :
                                  (rw_x > SMAX_X ? rtbb_pkg::SIZE_MAX : rw_x[SIZE_W-1:0]);
                s1_side_next.h  = c[3][CW-1] ? '0 :
                                  (rh_x > SMAX_X ? rtbb_pkg::SIZE_MAX : rh_x[SIZE_W-1:0]);
            end
            rtbb_pkg::KIND_QUAD:
            begin
                s1_side_next.status = rtbb_pkg::ST_OK;
                s1_side_next.quad   = 1'b1;
            end
            default:
            begin
                s1_side_next.status = rtbb_pkg::ST_BAD_KIND;
            end
        endcase
    end

    // ---------------- stage 2: squares, extents, centroid ----------------
    logic signed [CW:0]   exd, eyd;
    side_t                s2_side_next;
    logic [2*CW-1:0]      s2_sq_next [0:3];

    logic                 s2_vld_reg;
    side_t                s2_side_reg;
    logic [2*CW-1:0]      s2_sq_reg [0:3];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s2_sq_next[i] = (2*CW)'(s1_mag_reg[i]) * (2*CW)'(s1_mag_reg[i]);
        end
        exd = (CW+1)'(s1_xmax_reg) - (CW+1)'(s1_xmin_reg);
        eyd = (CW+1)'(s1_ymax_reg) - (CW+1)'(s1_ymin_reg);
        s2_side_next    = s1_side_reg;
        s2_side_next.ex = exd[CW-1:0];
        s2_side_next.ey = eyd[CW-1:0];
        s2_side_next.cx = CW'(s1_sx_reg >>> 2);
        s2_side_next.cy = CW'(s1_sy_reg >>> 2);
        if (s1_side_reg.quad && (exd == '0 || eyd == '0))
        begin
            s2_side_next.status = rtbb_pkg::ST_ZERO_AREA;
            s2_side_next.quad   = 1'b0;
        end
    end

    // ---------------- edge length roots, one bit per stage ----------------
    logic              e_vld_reg  [0:LW];
    side_t             e_side_reg [0:LW];
    logic [A2W-1:0]    e_a2_reg   [0:LW];
    logic [2*LW-1:0]   e_rad_reg  [0:LW][0:1];
    logic [ERW-1:0]    e_rem_reg  [0:LW][0:1];
    logic [LW-1:0]     e_root_reg [0:LW][0:1];
    logic [ERW-1:0]    e_rem_next  [0:LW-1][0:1];
    logic [LW-1:0]     e_root_next [0:LW-1][0:1];

    always_comb
    begin : edge_steps
        logic [ERW-1:0] sh;
        logic [ERW-1:0] tr;
        for (int k = 0; k < LW; k++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                sh = {e_rem_reg[k][j][ERW-3:0], e_rad_reg[k][j][2*(LW-1-k) +: 2]};
                tr = {e_root_reg[k][j], 2'b01};
                if (sh >= tr)
                begin
                    e_rem_next[k][j]  = sh - tr;
                    e_root_next[k][j] = {e_root_reg[k][j][LW-2:0], 1'b1};
                end
                else
                begin
                    e_rem_next[k][j]  = sh;
                    e_root_next[k][j] = {e_root_reg[k][j][LW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- divide L1*L2*2^32 by area, one bit per stage ----------------
    logic              d_vld_reg  [0:QW];
    side_t             d_side_reg [0:QW];
    logic [A1W-1:0]    d_a1_reg   [0:QW];
    logic [A2W-1:0]    d_a2_reg   [0:QW];
    logic [A2W-1:0]    d_rem_reg  [0:QW];
    logic [QW-1:0]     d_q_reg    [0:QW];
    logic [A2W-1:0]    d_rem_next [0:QW-1];
    logic [QW-1:0]     d_q_next   [0:QW-1];

    always_comb
    begin : div_steps
        logic [QW-1:0]  dvd;
        logic [A2W:0]   sh;
        for (int k = 0; k < QW; k++)
        begin
            dvd = {d_a1_reg[k], {(2*QF){1'b0}}};
            sh  = {d_rem_reg[k], dvd[QW-1-k]};
            if (sh >= {1'b0, d_a2_reg[k]})
            begin
                d_rem_next[k] = A2W'(sh - {1'b0, d_a2_reg[k]});
                d_q_next[k]   = {d_q_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                d_rem_next[k] = sh[A2W-1:0];
                d_q_next[k]   = {d_q_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    // ---------------- scale root, one bit per stage ----------------
    logic              r_vld_reg  [0:SW];
    side_t             r_side_reg [0:SW];
    logic [2*SW-1:0]   r_rad_reg  [0:SW];
    logic [SRW-1:0]    r_rem_reg  [0:SW];
    logic [SW-1:0]     r_root_reg [0:SW];
    logic [SRW-1:0]    r_rem_next  [0:SW-1];
    logic [SW-1:0]     r_root_next [0:SW-1];

    always_comb
    begin : root_steps
        logic [SRW-1:0] sh;
        logic [SRW-1:0] tr;
        for (int k = 0; k < SW; k++)
        begin
            sh = {r_rem_reg[k][SRW-3:0], r_rad_reg[k][2*(SW-1-k) +: 2]};
            tr = {r_root_reg[k], 2'b01};
            if (sh >= tr)
            begin
                r_rem_next[k]  = sh - tr;
                r_root_next[k] = {r_root_reg[k][SW-2:0], 1'b1};
            end
            else
            begin
                r_rem_next[k]  = sh;
                r_root_next[k] = {r_root_reg[k][SW-2:0], 1'b0};
            end
        end
    end

    // ---------------- scale times extent ----------------
    logic              m_vld_reg;
    side_t             m_side_reg;
    logic [PW-1:0]     m_pw_reg, m_ph_reg;

    // ---------------- final size, position, output register ----------------
    logic [TW-1:0]        tw, th;
    logic [SIZE_W-1:0]    qw, qh;
    logic signed [XW-1:0] qx_tl, qy_tl;
    logic [POS_W-1:0]     out_x_next, out_y_next;
    logic [SIZE_W-1:0]    out_w_next, out_h_next;

    logic                        out_vld_reg;
    logic [POS_W-1:0]            out_x_reg, out_y_reg;
    logic [SIZE_W-1:0]           out_w_reg, out_h_reg;
    logic [rtbb_pkg::ST_W-1:0]   out_st_reg;

    always_comb
    begin
        tw = TW'(m_pw_reg[PW-1:QF]) + ONE_T;
        th = TW'(m_ph_reg[PW-1:QF]) + ONE_T;
        qw = (tw > SMAX_T) ? rtbb_pkg::SIZE_MAX : tw[SIZE_W-1:0];
        qh = (th > SMAX_T) ? rtbb_pkg::SIZE_MAX : th[SIZE_W-1:0];
        qx_tl = XW'(m_side_reg.cx) - XW'(qw >> 1);
        qy_tl = XW'(m_side_reg.cy) - XW'(qh >> 1);
        if (m_side_reg.quad)
        begin
            out_w_next = qw;
            out_h_next = qh;
            out_x_next = m_side_reg.center ? POS_W'(XW'(m_side_reg.cx)) : qx_tl[POS_W-1:0];
            out_y_next = m_side_reg.center ? POS_W'(XW'(m_side_reg.cy)) : qy_tl[POS_W-1:0];
        end
        else
        begin
            // rectangle results, or zeros for a rejected request
            out_w_next = m_side_reg.w;
            out_h_next = m_side_reg.h;
            out_x_next = m_side_reg.px;
            out_y_next = m_side_reg.py;
        end
    end

    // whole pipe moves unless a finished result waits
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            center_reg <= cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            for (int k = 0; k <= LW; k++)
            begin
                e_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= QW; k++)
            begin
                d_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= SW; k++)
            begin
                r_vld_reg[k] <= 1'b0;
            end
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg   <= s_axis_tvalid;
            s2_vld_reg   <= s1_vld_reg;
            e_vld_reg[0] <= s2_vld_reg;
            for (int k = 0; k < LW; k++)
            begin
                e_vld_reg[k+1] <= e_vld_reg[k];
            end
            d_vld_reg[0] <= e_vld_reg[LW];
            for (int k = 0; k < QW; k++)
            begin
                d_vld_reg[k+1] <= d_vld_reg[k];
            end
            r_vld_reg[0] <= d_vld_reg[QW];
            for (int k = 0; k < SW; k++)
            begin
                r_vld_reg[k+1] <= r_vld_reg[k];
            end
            m_vld_reg   <= r_vld_reg[SW];
            out_vld_reg <= m_vld_reg;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            for (int i = 0; i < 4; i++)
            begin
                s1_mag_reg[i] <= s1_mag_next[i];
            end
            s1_xmin_reg <= s1_xmin_next;
            s1_xmax_reg <= s1_xmax_next;
            s1_ymin_reg <= s1_ymin_next;
            s1_ymax_reg <= s1_ymax_next;
            s1_sx_reg   <= s1_sx_next;
            s1_sy_reg   <= s1_sy_next;

            s2_side_reg <= s2_side_next;
            for (int i = 0; i < 4; i++)
            begin
                s2_sq_reg[i] <= s2_sq_next[i];
            end

            // edge root entry: squared lengths and the box area
            e_side_reg[0]   <= s2_side_reg;
            e_a2_reg[0]     <= (2*CW)'(s2_side_reg.ex) * (2*CW)'(s2_side_reg.ey);
            e_rad_reg[0][0] <= (2*LW)'(s2_sq_reg[0]) + (2*LW)'(s2_sq_reg[1]);
            e_rad_reg[0][1] <= (2*LW)'(s2_sq_reg[2]) + (2*LW)'(s2_sq_reg[3]);
            for (int j = 0; j < 2; j++)
            begin
                e_rem_reg[0][j]  <= '0;
                e_root_reg[0][j] <= '0;
            end
            for (int k = 0; k < LW; k++)
            begin
                e_side_reg[k+1] <= e_side_reg[k];
                e_a2_reg[k+1]   <= e_a2_reg[k];
                for (int j = 0; j < 2; j++)
                begin
                    e_rad_reg[k+1][j]  <= e_rad_reg[k][j];
                    e_rem_reg[k+1][j]  <= e_rem_next[k][j];
                    e_root_reg[k+1][j] <= e_root_next[k][j];
                end
            end

            // divider entry: product of both edge lengths
            d_side_reg[0] <= e_side_reg[LW];
            d_a1_reg[0]   <= A1W'(e_root_reg[LW][0]) * A1W'(e_root_reg[LW][1]);
            d_a2_reg[0]   <= e_a2_reg[LW];
            d_rem_reg[0]  <= '0;
            d_q_reg[0]    <= '0;
            for (int k = 0; k < QW; k++)
            begin
                d_side_reg[k+1] <= d_side_reg[k];
                d_a1_reg[k+1]   <= d_a1_reg[k];
                d_a2_reg[k+1]   <= d_a2_reg[k];
                d_rem_reg[k+1]  <= d_rem_next[k];
                d_q_reg[k+1]    <= d_q_next[k];
            end

            r_side_reg[0] <= d_side_reg[QW];
            r_rad_reg[0]  <= (2*SW)'(d_q_reg[QW]);
            r_rem_reg[0]  <= '0;
            r_root_reg[0] <= '0;
            for (int k = 0; k < SW; k++)
            begin
                r_side_reg[k+1] <= r_side_reg[k];
                r_rad_reg[k+1]  <= r_rad_reg[k];
                r_rem_reg[k+1]  <= r_rem_next[k];
                r_root_reg[k+1] <= r_root_next[k];
            end

            m_side_reg <= r_side_reg[SW];
            m_pw_reg   <= PW'(r_root_reg[SW]) * PW'(r_side_reg[SW].ex);
            m_ph_reg   <= PW'(r_root_reg[SW]) * PW'(r_side_reg[SW].ey);

            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            out_w_reg  <= out_w_next;
            out_h_reg  <= out_h_next;
            out_st_reg <= m_side_reg.status;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{rtbb_pkg::OUT_PAD{1'b0}}, out_h_reg, out_w_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_st_reg;

endmodule

FILE: sv/rtbb_checker.sv
// Port-level checks of the region to bounding box converter, bound to its top level.
module rtbb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [rtbb_pkg::OUT_DW-1:0] m_axis_tdata,
    input logic [rtbb_pkg::ST_W-1:0]   m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // input ready follows the output stage
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output stall");

    // rejected requests carry a zero box
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != rtbb_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero box with error status");

    // legal status code and clean padding
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == rtbb_pkg::ST_OK || m_axis_tuser == rtbb_pkg::ST_BAD_KIND ||
             m_axis_tuser == rtbb_pkg::ST_ZERO_AREA) &&
            m_axis_tdata[rtbb_pkg::OUT_DW-1 -: rtbb_pkg::OUT_PAD] == '0)
        else $error("bad status code or padding");

endmodule

bind region_to_bounding_box rtbb_checker u_rtbb_checker (.*);
